[src/bwll_pkg.sv]
// Shared constants and types for the band-weighted line-length average.
// No dependencies; imported by every module of the block.
`default_nettype none

package bwll_pkg;

   // default sizing for the top-level parameters
   localparam int DEF_MAX_WINDOW  = 65536;
   localparam int DEF_SAMPLE_BITS = 16;

   // fixed field widths
   localparam int GAIN_W     = 16;
   localparam int LEN_W      = 17;
   localparam int OUT_W      = 26;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // arithmetic shape
   localparam int FRAC_BITS  = 10;   // Q5.10 gains
   localparam int COMB_GUARD = 6;    // combined sample is SAMPLE_BITS+6 bits
   localparam int AVG_SCALE  = 10;   // result is ten times the mean
   localparam int SCALE_W    = 4;    // bits that AVG_SCALE adds

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ALPHA = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_BETA  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DELTA = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = CSR_IDX_W'(3);

   typedef logic signed [GAIN_W-1:0] gain_type;

   typedef struct packed {
      gain_type alpha;
      gain_type beta;
      gain_type delta;
   } gain_set_type;

   // reset values
   localparam gain_type GAIN_ALPHA_RST = GAIN_W'(4096);
   localparam gain_type GAIN_BETA_RST  = GAIN_W'(7168);
   localparam gain_type GAIN_DELTA_RST = GAIN_W'(-1024);
   localparam logic [LEN_W-1:0] WINDOW_LEN_RST = LEN_W'(1000);

endpackage

`default_nettype wire

[src/bwll_front.sv]
// Front end: weights the three band samples, forms the saturated combined
// sample and its absolute step from the previous one. Uses bwll_pkg.
`default_nettype none

module bwll_front #(
   parameter int SAMPLE_BITS = bwll_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  bwll_pkg::gain_set_type                   gains,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic signed [SAMPLE_BITS-1:0]            in_alpha,
   input  logic signed [SAMPLE_BITS-1:0]            in_beta,
   input  logic signed [SAMPLE_BITS-1:0]            in_delta,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic                                     out_use,
   output logic [SAMPLE_BITS+bwll_pkg::COMB_GUARD:0] out_diff
);
   import bwll_pkg::*;

   localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int SHIFT_W = SUM_W - FRAC_BITS;
   localparam int COMB_W  = SAMPLE_BITS + COMB_GUARD;
   localparam int DIFF_W  = COMB_W + 1;

   logic adv;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [PROD_W-1:0] pa_ff, pa_in, pb_ff, pb_in, pd_ff, pd_in;
   logic signed [COMB_W-1:0] comb_ff, comb_in, prev_ff, prev_in;
   logic primed_ff, primed_in, use_ff, use_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;

   logic signed [PROD_W-1:0] a_ext, b_ext, d_ext, ga_ext, gb_ext, gd_ext;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SHIFT_W-1:0] sh;
   logic signed [DIFF_W-1:0] dd;

   // pipeline moves whenever the last stage is empty or drains
   assign adv       = !v3_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = v3_ff;
   assign out_use   = use_ff;
   assign out_diff  = diff_ff;

   // stage 1: three products
   assign a_ext  = PROD_W'(in_alpha);
   assign b_ext  = PROD_W'(in_beta);
   assign d_ext  = PROD_W'(in_delta);
   assign ga_ext = PROD_W'(gains.alpha);
   assign gb_ext = PROD_W'(gains.beta);
   assign gd_ext = PROD_W'(gains.delta);

   // stage 2: sum, floor by 1024, saturate
   assign sum = SUM_W'(pa_ff) + SUM_W'(pb_ff) + SUM_W'(pd_ff);
   assign sh  = sum[SUM_W-1:FRAC_BITS];

   // stage 3: step from previous combined sample
   assign dd = DIFF_W'(comb_ff) - DIFF_W'(prev_ff);

   always_comb begin
      v1_in     = v1_ff;
      v2_in     = v2_ff;
      v3_in     = v3_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      pd_in     = pd_ff;
      comb_in   = comb_ff;
      prev_in   = prev_ff;
      primed_in = primed_ff;
      use_in    = use_ff;
      diff_in   = diff_ff;
      if (adv) begin
         v1_in = in_valid;
         v2_in = v1_ff;
         v3_in = v2_ff;
         pa_in = a_ext * ga_ext;
         pb_in = b_ext * gb_ext;
         pd_in = d_ext * gd_ext;
         priority if (sh[SHIFT_W-1:COMB_W-1] == '0 || sh[SHIFT_W-1:COMB_W-1] == '1) begin
            comb_in = sh[COMB_W-1:0];
         end else if (sh[SHIFT_W-1]) begin
            comb_in = {1'b1, {(COMB_W-1){1'b0}}};
         end else begin
            comb_in = {1'b0, {(COMB_W-1){1'b1}}};
         end
         use_in  = primed_ff;
         diff_in = dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
         if (v2_ff) begin
            prev_in   = comb_ff;
            primed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         primed_ff <= 1'b0;
         prev_ff   <= '0;
      end else begin
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
         primed_ff <= primed_in;
         prev_ff   <= prev_in;
      end
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      pd_ff   <= pd_in;
      comb_ff <= comb_in;
      use_ff  <= use_in;
      diff_ff <= diff_in;
   end

endmodule

`default_nettype wire

[src/bwll_queue.sv]
// Short FIFO between the front end and the window update.
// Uses bwll_pkg for its depth.
`default_nettype none

module bwll_queue #(
   parameter int WIDTH = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import bwll_pkg::*;

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill tracking
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

[src/bwll_back.sv]
// Window update: ring memory of step sizes with a running total.
// Uses bwll_pkg; fed by bwll_queue, feeds bwll_div.
`default_nettype none

module bwll_back #(
   parameter int MAX_WINDOW = bwll_pkg::DEF_MAX_WINDOW,
   parameter int DIFF_W     = bwll_pkg::DEF_SAMPLE_BITS + bwll_pkg::COMB_GUARD + 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]          win,
   input  logic                                     clear,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [DIFF_W:0]                          in_data,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [DIFF_W+$clog2(MAX_WINDOW)-1:0]     out_total
);
   import bwll_pkg::*;

   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int ADDR_W = $clog2(MAX_WINDOW);
   localparam int TOT_W  = DIFF_W + ADDR_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [DIFF_W-1:0] ring_mem [MAX_WINDOW];
   logic [DIFF_W-1:0] rd_data_ff;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              full_ff, full_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;
   logic [DIFF_W-1:0] old_diff;
   logic [WIN_W-1:0]  next_pos;
   logic              mem_we;

   assign in_ready  = state_ff == ST_IDLE;
   assign out_valid = state_ff == ST_SEND;
   assign out_total = total_ff;
   assign mem_we    = state_ff == ST_UPD;

   // entries past the fill point were never written since the last clear
   assign old_diff = full_ff ? rd_data_ff : '0;
   assign next_pos = WIN_W'(pos_ff) + WIN_W'(1);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      full_in  = full_ff;
      total_in = total_ff;
      diff_in  = diff_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               diff_in  = in_data[DIFF_W-1:0];
               state_in = in_data[DIFF_W] ? ST_UPD : ST_SEND;
            end
         end
         ST_UPD: begin
            total_in = total_ff - TOT_W'(old_diff) + TOT_W'(diff_ff);
            if (next_pos == win) begin
               pos_in  = '0;
               full_in = 1'b1;
            end else begin
               pos_in = next_pos[ADDR_W-1:0];
            end
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (clear) begin
         pos_in   = '0;
         full_in  = 1'b0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         full_ff  <= 1'b0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         full_ff  <= full_in;
         total_ff <= total_in;
      end
      diff_ff <= diff_in;
   end

   // ring memory, read-before-write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[pos_ff] <= diff_ff;
      end
      rd_data_ff <= ring_mem[pos_ff];
   end

   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      WIN_W'(pos_ff) < win)
      else $error("ring position outside window");

endmodule

`default_nettype wire

[src/bwll_div.sv]
// Bit-serial divider: ten times the window total over the window length,
// one quotient bit per cycle, with the result word register. Uses bwll_pkg.
`default_nettype none

module bwll_div #(
   parameter int MAX_WINDOW = bwll_pkg::DEF_MAX_WINDOW,
   parameter int DIFF_W     = bwll_pkg::DEF_SAMPLE_BITS + bwll_pkg::COMB_GUARD + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]      win,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [DIFF_W+$clog2(MAX_WINDOW)-1:0] in_total,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [bwll_pkg::OUT_W-1:0]           out_quot
);
   import bwll_pkg::*;

   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int ADDR_W = $clog2(MAX_WINDOW);
   localparam int TOT_W  = DIFF_W + ADDR_W;
   localparam int DVD_W  = TOT_W + SCALE_W;
   localparam int Q_W    = DIFF_W + SCALE_W;
   localparam int CNT_W  = $clog2(Q_W + 1);

   localparam logic [1:0] DV_IDLE = 2'd0;
   localparam logic [1:0] DV_STEP = 2'd1;
   localparam logic [1:0] DV_HOLD = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [WIN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [Q_W-1:0]   num_ff, num_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovalid_ff, ovalid_in;
   logic [OUT_W-1:0] odata_ff, odata_in;

   logic [DVD_W-1:0] dvd;
   logic [WIN_W:0]   trial, trial_sub;
   logic             ge;

   assign in_ready  = state_ff == DV_IDLE;
   assign out_valid = ovalid_ff;
   assign out_quot  = odata_ff;

   // ten times the total as two shifted copies
   assign dvd = (DVD_W'(in_total) << 3) + (DVD_W'(in_total) << 1);

   // one restoring step
   assign trial     = {rem_ff, num_ff[Q_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign ge        = trial >= {1'b0, den_ff};

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      cnt_in    = cnt_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      if (ovalid_ff && out_ready) begin
         ovalid_in = 1'b0;
      end
      unique case (state_ff)
         DV_IDLE: begin
            if (in_valid) begin
               // high part is below the divisor, so the quotient fits Q_W bits
               rem_in   = WIN_W'(dvd[DVD_W-1:Q_W]);
               num_in   = dvd[Q_W-1:0];
               den_in   = win;
               cnt_in   = CNT_W'(Q_W);
               state_in = DV_STEP;
            end
         end
         DV_STEP: begin
            rem_in = ge ? trial_sub[WIN_W-1:0] : trial[WIN_W-1:0];
            num_in = {num_ff[Q_W-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = DV_HOLD;
            end
         end
         DV_HOLD: begin
            if (!ovalid_ff || out_ready) begin
               ovalid_in = 1'b1;
               odata_in  = OUT_W'(num_ff);
               state_in  = DV_IDLE;
            end
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= DV_IDLE;
         ovalid_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      num_ff   <= num_in;
      odata_ff <= odata_in;
   end

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DV_STEP) |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

[src/band_weighted_line_length_average.sv]
// Top level of the band-weighted line-length average: register bank and
// the front / queue / window / divider chain. Uses bwll_pkg and all bwll_ modules.
//
//   channel  ports                        word
//   req      req_valid / req_ready        alpha, beta, delta band samples
//   rsp      rsp_valid / rsp_ready        line_length
//   csr      csr_valid / csr_ready        csr_index, csr_data
//
// The one-bit-per-cycle divider forms a quotient of SAMPLE_BITS + 11 bits (27 by default)
// and sets the sustained rate: it takes a new total only after registering its last result.
// The front end keeps taking words until the queue is full and its last stage holds one.
// Reset is synchronous; the ring needs no clearing pass, a fill flag masks old entries.
// A held rsp word does not block the divider from taking the next total.
`default_nettype none

module band_weighted_line_length_average #(
   parameter int MAX_WINDOW  = bwll_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = bwll_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_alpha_sample,
   input  logic signed [SAMPLE_BITS-1:0]       req_beta_sample,
   input  logic signed [SAMPLE_BITS-1:0]       req_delta_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bwll_pkg::OUT_W-1:0]          rsp_line_length,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bwll_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bwll_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bwll_pkg::*;

   localparam int DIFF_W = SAMPLE_BITS + COMB_GUARD + 1;
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int ADDR_W = $clog2(MAX_WINDOW);
   localparam int TOT_W  = DIFF_W + ADDR_W;
   localparam int CMP_W  = (WIN_W > LEN_W) ? WIN_W : LEN_W;

   gain_set_type     gains_ff, gains_in;
   logic [LEN_W-1:0] window_len_ff, window_len_in;
   logic             csr_write, win_clear;
   logic [CMP_W-1:0] len_ext;
   logic [WIN_W-1:0] win;

   logic              f_valid, f_ready, f_use;
   logic [DIFF_W-1:0] f_diff;
   logic              q_valid, q_ready;
   logic [DIFF_W:0]   q_data;
   logic              b_valid, b_ready;
   logic [TOT_W-1:0]  b_total;

   // register bank, always writable
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      gains_in      = gains_ff;
      window_len_in = window_len_ff;
      win_clear     = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_ALPHA: gains_in.alpha = $signed(csr_data[GAIN_W-1:0]);
            CSR_GAIN_BETA:  gains_in.beta  = $signed(csr_data[GAIN_W-1:0]);
            CSR_GAIN_DELTA: gains_in.delta = $signed(csr_data[GAIN_W-1:0]);
            CSR_WINDOW_LEN: begin
               window_len_in = csr_data[LEN_W-1:0];
               win_clear     = 1'b1;
            end
            default: begin
               gains_in = gains_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.alpha <= GAIN_ALPHA_RST;
         gains_ff.beta  <= GAIN_BETA_RST;
         gains_ff.delta <= GAIN_DELTA_RST;
         window_len_ff  <= WINDOW_LEN_RST;
      end else begin
         gains_ff      <= gains_in;
         window_len_ff <= window_len_in;
      end
   end

   // window length in force: zero acts as one, clipped to the ring size
   assign len_ext = CMP_W'(window_len_ff);

   always_comb begin
      priority if (len_ext == '0) begin
         win = WIN_W'(1);
      end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
         win = WIN_W'(MAX_WINDOW);
      end else begin
         win = WIN_W'(len_ext);
      end
   end

   bwll_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_alpha  (req_alpha_sample),
      .in_beta   (req_beta_sample),
      .in_delta  (req_delta_sample),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_use   (f_use),
      .out_diff  (f_diff)
   );

   bwll_queue #(
      .WIDTH (DIFF_W + 1)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_use, f_diff}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   bwll_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .DIFF_W     (DIFF_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .win       (win),
      .clear     (win_clear),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_total (b_total)
   );

   bwll_div #(
      .MAX_WINDOW (MAX_WINDOW),
      .DIFF_W     (DIFF_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .win       (win),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_total  (b_total),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_quot  (rsp_line_length)
   );

endmodule

`default_nettype wire
